@@ src/wsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_pkg: shared types and constants for the walk / sprint intent block
// Payload structs, classified queue entry, configuration bundle and codes.
// ----------------------------------------------------------------------------
package wsi_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_MOVE_DEADZONE    = 3'd0;
   localparam logic [2:0] CSR_SPRINT_LEVEL     = 3'd1;
   localparam logic [2:0] CSR_STALE_TIMEOUT_MS = 3'd2;
   localparam logic [2:0] CSR_COAST_MAX_US     = 3'd3;
   localparam logic [2:0] CSR_SPRINT_ENTER_US  = 3'd4;
   localparam logic [2:0] CSR_SPRINT_EXIT_US   = 3'd5;
   localparam logic [2:0] CSR_FORWARD_STICK    = 3'd6;

   localparam int CSR_DATA_W = 27;

   // Configuration reset values
   localparam logic [15:0]        RST_MOVE_DEADZONE    = 16'd4000;
   localparam logic [15:0]        RST_SPRINT_LEVEL     = 16'd30000;
   localparam logic [19:0]        RST_STALE_TIMEOUT_MS = 20'd500;
   localparam logic [26:0]        RST_COAST_MAX_US     = 27'd300000;
   localparam logic [26:0]        RST_SPRINT_ENTER_US  = 27'd200000;
   localparam logic [26:0]        RST_SPRINT_EXIT_US   = 27'd300000;
   localparam logic signed [15:0] RST_FORWARD_STICK    = 16'sd32767;

   // Fixed limits
   localparam logic [19:0] AGE_CAP         = 20'd999999;
   localparam logic [16:0] DT_CAP_US       = 17'd100000;
   localparam logic [8:0]  SHOULDER_BUTTON = 9'h100;

   // Intent codes on the result channel
   localparam logic [1:0] INTENT_STOPPED   = 2'd0;
   localparam logic [1:0] INTENT_WALKING   = 2'd1;
   localparam logic [1:0] INTENT_SPRINTING = 2'd2;

   typedef enum logic [2:0] {
      CAUSE_HOLD         = 3'd0,
      CAUSE_STALE        = 3'd1,
      CAUSE_START        = 3'd2,
      CAUSE_COAST        = 3'd3,
      CAUSE_SPRINT_ENTER = 3'd4,
      CAUSE_SPRINT_EXIT  = 3'd5
   } cause_type;

   typedef enum logic [2:0] {
      MODE_STOPPED   = 3'b001,
      MODE_WALKING   = 3'b010,
      MODE_SPRINTING = 3'b100
   } mode_type;

   typedef struct packed {
      logic                link_up;
      logic signed [15:0]  stick_value;
      logic                device_sprint;
      logic [47:0]         sample_time_ms;
      logic [47:0]         now_ms;
      logic [19:0]         elapsed_us;
      logic [31:0]         sample_seq;
   } req_type;

   typedef struct packed {
      logic [1:0]          intent;
      logic [2:0]          cause;
      logic                is_stale;
      logic [19:0]         age_ms;
      logic [47:0]         time_echo;
      logic [31:0]         seq_echo;
      logic signed [15:0]  stick_echo;
      logic                sprint_echo;
      logic signed [15:0]  drive_y;
      logic [8:0]          button_mask;
   } rsp_type;

   typedef struct packed {
      logic [15:0]         move_deadzone;
      logic [15:0]         sprint_level;
      logic [19:0]         stale_timeout_ms;
      logic [26:0]         coast_max_us;
      logic [26:0]         sprint_enter_us;
      logic [26:0]         sprint_exit_us;
      logic signed [15:0]  forward_stick;
   } cfg_type;

   // One classified update as it waits between front and back
   typedef struct packed {
      logic                fresh;
      logic                moving;
      logic                sprint;
      logic [16:0]         dt_us;
      logic [19:0]         age_ms;
      logic [47:0]         now_ms;
      logic [31:0]         sample_seq;
      logic signed [15:0]  stick_value;
      logic                device_sprint;
   } cls_type;

endpackage

@@ src/wsi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_front: update classifier
// Works out freshness, capped age, clamped step time and movement / sprint.
// ----------------------------------------------------------------------------
module wsi_front (
   input  wsi_pkg::req_type req_data,
   input  wsi_pkg::cfg_type cfg,
   output wsi_pkg::cls_type cls
);

   logic        has_time;
   logic [47:0] diff;
   logic [16:0] mag;
   logic [15:0] dz;
   logic [15:0] sl;

   always_comb begin
      has_time = (req_data.sample_time_ms != 48'd0) &&
                 (req_data.now_ms >= req_data.sample_time_ms);
      diff     = req_data.now_ms - req_data.sample_time_ms;

      // magnitude of a 16-bit two's complement value, 0..32768
      if (req_data.stick_value[15]) begin
         mag = 17'h10000 - {1'b0, req_data.stick_value};
      end else begin
         mag = {1'b0, req_data.stick_value};
      end

      // a zero threshold acts as one
      dz = (cfg.move_deadzone == 16'd0) ? 16'd1 : cfg.move_deadzone;
      sl = (cfg.sprint_level == 16'd0) ? 16'd1 : cfg.sprint_level;

      cls.fresh  = req_data.link_up && has_time &&
                   (diff <= {28'd0, cfg.stale_timeout_ms});
      cls.age_ms = (has_time && (diff < {28'd0, wsi_pkg::AGE_CAP})) ?
                   diff[19:0] : wsi_pkg::AGE_CAP;
      cls.dt_us  = (req_data.elapsed_us > {3'd0, wsi_pkg::DT_CAP_US}) ?
                   wsi_pkg::DT_CAP_US : req_data.elapsed_us[16:0];
      cls.moving = (mag >= {1'b0, dz});
      cls.sprint = req_data.device_sprint || (mag >= {1'b0, sl});

      cls.now_ms        = req_data.now_ms;
      cls.sample_seq    = req_data.sample_seq;
      cls.stick_value   = req_data.stick_value;
      cls.device_sprint = req_data.device_sprint;
   end

endmodule

@@ src/wsi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_queue: classified update queue
// Short FIFO between the classifier and the state machine.
// ----------------------------------------------------------------------------
module wsi_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wsi_pkg::cls_type push_data,
   input  logic             pop,
   output wsi_pkg::cls_type pop_data,
   output logic             full,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   wsi_pkg::cls_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue holds more entries than its depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

endmodule

@@ src/wsi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_back: intent state machine and result register
// Steps mode and time accumulators for each classified update.
// ----------------------------------------------------------------------------
module wsi_back (
   input  logic             clock,
   input  logic             reset,
   input  wsi_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  wsi_pkg::cls_type q_data,
   output logic             q_pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output wsi_pkg::rsp_type rsp_data
);

   wsi_pkg::mode_type  mode_ff, mode_in;
   logic [31:0]        idle_ff, idle_in;
   logic [31:0]        on_ff, on_in;
   logic [31:0]        off_ff, off_in;
   wsi_pkg::cause_type cause;
   logic               coast_hit;
   logic               rsp_valid_ff;
   wsi_pkg::rsp_type   rsp_data_ff, rsp_in;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [16:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {16'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // take the next entry when the result register is free or being drained
   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      mode_in   = mode_ff;
      idle_in   = idle_ff;
      on_in     = on_ff;
      off_in    = off_ff;
      cause     = wsi_pkg::CAUSE_HOLD;
      coast_hit = 1'b0;
      if (!q_data.fresh) begin
         if (mode_ff != wsi_pkg::MODE_STOPPED) begin
            cause = wsi_pkg::CAUSE_STALE;
         end
         mode_in = wsi_pkg::MODE_STOPPED;
         idle_in = '0;
         on_in   = '0;
         off_in  = '0;
      end else begin
         idle_in = q_data.moving ? 32'd0 : sat_add(idle_ff, q_data.dt_us);
         if (q_data.sprint) begin
            on_in  = sat_add(on_ff, q_data.dt_us);
            off_in = '0;
         end else begin
            off_in = sat_add(off_ff, q_data.dt_us);
            on_in  = '0;
         end
         coast_hit = !q_data.moving && (idle_in >= {5'd0, cfg.coast_max_us});
         case (mode_ff)
            wsi_pkg::MODE_WALKING: begin
               if (coast_hit) begin
                  mode_in = wsi_pkg::MODE_STOPPED;
                  cause   = wsi_pkg::CAUSE_COAST;
               end else if (on_in >= {5'd0, cfg.sprint_enter_us}) begin
                  mode_in = wsi_pkg::MODE_SPRINTING;
                  cause   = wsi_pkg::CAUSE_SPRINT_ENTER;
               end
            end
            wsi_pkg::MODE_SPRINTING: begin
               if (coast_hit) begin
                  mode_in = wsi_pkg::MODE_STOPPED;
                  cause   = wsi_pkg::CAUSE_COAST;
               end else if (off_in >= {5'd0, cfg.sprint_exit_us}) begin
                  mode_in = wsi_pkg::MODE_WALKING;
                  cause   = wsi_pkg::CAUSE_SPRINT_EXIT;
               end
            end
            default: begin
               mode_in = wsi_pkg::MODE_STOPPED;
               if (q_data.moving) begin
                  mode_in = wsi_pkg::MODE_WALKING;
                  cause   = wsi_pkg::CAUSE_START;
               end
            end
         endcase
      end

      rsp_in.cause       = cause;
      rsp_in.is_stale    = !q_data.fresh;
      rsp_in.age_ms      = q_data.age_ms;
      rsp_in.time_echo   = q_data.now_ms;
      rsp_in.seq_echo    = q_data.sample_seq;
      rsp_in.stick_echo  = q_data.stick_value;
      rsp_in.sprint_echo = q_data.device_sprint;
      case (mode_in)
         wsi_pkg::MODE_WALKING: begin
            rsp_in.intent      = wsi_pkg::INTENT_WALKING;
            rsp_in.drive_y     = cfg.forward_stick;
            rsp_in.button_mask = '0;
         end
         wsi_pkg::MODE_SPRINTING: begin
            rsp_in.intent      = wsi_pkg::INTENT_SPRINTING;
            rsp_in.drive_y     = cfg.forward_stick;
            rsp_in.button_mask = wsi_pkg::SHOULDER_BUTTON;
         end
         default: begin
            rsp_in.intent      = wsi_pkg::INTENT_STOPPED;
            rsp_in.drive_y     = '0;
            rsp_in.button_mask = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= wsi_pkg::MODE_STOPPED;
         idle_ff      <= '0;
         on_ff        <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            mode_ff      <= mode_in;
            idle_ff      <= idle_in;
            on_ff        <= on_in;
            off_ff       <= off_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_in;
      end
   end

   a_stale_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_data.fresh) |=>
         (mode_ff == wsi_pkg::MODE_STOPPED) && (idle_ff == '0) &&
         (on_ff == '0) && (off_ff == '0))
      else $error("stale update did not stop and clear accumulators");

   a_no_jump_to_sprint: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == wsi_pkg::MODE_STOPPED) |=> (mode_ff != wsi_pkg::MODE_SPRINTING))
      else $error("stopped went straight to sprinting");

   a_sprint_exclusive: assert property (@(posedge clock) disable iff (reset)
      (on_ff == '0) || (off_ff == '0))
      else $error("sprint on and off timers both running");

endmodule

@@ src/walk_sprint_intent_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walk_sprint_intent_fsm: walk / sprint intent from locomotion sensor updates
// Classifies each update and steps a stopped / walking / sprinting machine.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  one sensor update per transfer (req_valid high, req_stall low).
//          req_stall rises only when the internal queue is full.
//   rsp_*  one result per update, in order; the receiver holds rsp_stall
//          high to keep the current result on rsp_data.
//   csr_*  register writes, index 0..6; csr_ready is always high and an
//          unknown index is dropped. Write only while no update is in flight.
// Path: an accepted update is written into the queue, then popped into the
//   result register that drives rsp_*; a stalled result holds back the pop.
// Throughput: one update per cycle while rsp_stall is low, with a combinational
//   classifier in front and a registered state step in back.
// Stall: a stalled result holds in the output register; updates keep
//   flowing into the queue until it holds QUEUE_DEPTH entries.
// Reset: mode returns to stopped, timers clear, registers take their
//   default values, queue and result register empty.
// ----------------------------------------------------------------------------
module walk_sprint_intent_fsm #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wsi_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wsi_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [wsi_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   wsi_pkg::cfg_type cfg_ff;
   wsi_pkg::cls_type front_cls;
   wsi_pkg::cls_type q_data;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   logic             push;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Configuration registers: take a write on each csr transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_deadzone    <= wsi_pkg::RST_MOVE_DEADZONE;
         cfg_ff.sprint_level     <= wsi_pkg::RST_SPRINT_LEVEL;
         cfg_ff.stale_timeout_ms <= wsi_pkg::RST_STALE_TIMEOUT_MS;
         cfg_ff.coast_max_us     <= wsi_pkg::RST_COAST_MAX_US;
         cfg_ff.sprint_enter_us  <= wsi_pkg::RST_SPRINT_ENTER_US;
         cfg_ff.sprint_exit_us   <= wsi_pkg::RST_SPRINT_EXIT_US;
         cfg_ff.forward_stick    <= wsi_pkg::RST_FORWARD_STICK;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wsi_pkg::CSR_MOVE_DEADZONE:    cfg_ff.move_deadzone    <= csr_wdata[15:0];
            wsi_pkg::CSR_SPRINT_LEVEL:     cfg_ff.sprint_level     <= csr_wdata[15:0];
            wsi_pkg::CSR_STALE_TIMEOUT_MS: cfg_ff.stale_timeout_ms <= csr_wdata[19:0];
            wsi_pkg::CSR_COAST_MAX_US:     cfg_ff.coast_max_us     <= csr_wdata[26:0];
            wsi_pkg::CSR_SPRINT_ENTER_US:  cfg_ff.sprint_enter_us  <= csr_wdata[26:0];
            wsi_pkg::CSR_SPRINT_EXIT_US:   cfg_ff.sprint_exit_us   <= csr_wdata[26:0];
            wsi_pkg::CSR_FORWARD_STICK:    cfg_ff.forward_stick    <= csr_wdata[15:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // Front: classify the update as it is accepted
   wsi_front u_front (
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cls      (front_cls)
   );

   // Queue: decouple the classifier from the state step
   wsi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cls),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .not_empty (q_valid)
   );

   // Back: advance the intent machine and register the result
   wsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the walk / sprint intent block
// Streams sensor updates through the req channel under random idling and
// result backpressure. An update-by-update model of the intent machine predicts
// every result, and the monitor compares the results field by field in order.
// Register settings change between phases, and only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [2:0] CSR_UNUSED  = 3'd7;      // no register here, write is dropped
   localparam int         CYCLE_LIMIT = 2_000_000;
   localparam int         SOAK_LEN    = 8;         // stopped with sprint held, timer builds
   localparam int         PHASE_LEN   = 320;
   localparam int         PRINT_CAP   = 40;

   // ------------------------------------------------------------------------
   // DUT connections. Every input holds a known value from time zero.
   // ------------------------------------------------------------------------
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   wsi_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   wsi_pkg::rsp_type               rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [2:0]                     csr_index = '0;
   logic [wsi_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   walk_sprint_intent_fsm u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   wsi_pkg::req_type update_queue [$];     // updates waiting for the driver
   wsi_pkg::rsp_type intent_due [$];       // predicted results, oldest first
   wsi_pkg::rsp_type intent_next;
   logic        req_took  = 1'b0;     // a req transfer happened at the last rising edge
   logic        csr_took  = 1'b0;     // a csr transfer happened at the last rising edge
   int          req_gap   = 0;
   int          rsp_gap   = 0;
   int          gap_odds  = 0;        // percent chance of starting an idle burst
   int          cycle_count     = 0;
   int          mismatch_count  = 0;
   int          results_checked = 0;
   int          setting_count   = 0;
   int          cause_tally [8];
   logic [47:0] now_clk;              // running wall clock in ms for generated updates

   // Shadow of the intent machine: register file plus its own state
   wsi_pkg::cfg_type reg_shadow = '{
      move_deadzone:    wsi_pkg::RST_MOVE_DEADZONE,
      sprint_level:     wsi_pkg::RST_SPRINT_LEVEL,
      stale_timeout_ms: wsi_pkg::RST_STALE_TIMEOUT_MS,
      coast_max_us:     wsi_pkg::RST_COAST_MAX_US,
      sprint_enter_us:  wsi_pkg::RST_SPRINT_ENTER_US,
      sprint_exit_us:   wsi_pkg::RST_SPRINT_EXIT_US,
      forward_stick:    wsi_pkg::RST_FORWARD_STICK
   };
   logic [1:0]  walk_mode      = wsi_pkg::INTENT_STOPPED;
   logic [31:0] still_us       = '0;  // time without movement
   logic [31:0] sprint_held_us = '0;  // time with sprint seen
   logic [31:0] sprint_gone_us = '0;  // time without sprint seen

   // ------------------------------------------------------------------------
   // Intent prediction
   // ------------------------------------------------------------------------
   function automatic logic [31:0] add_clamped(logic [31:0] a, logic [19:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {13'd0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // Advance the shadow machine by one update and return the result it owes.
   function automatic wsi_pkg::rsp_type predict_intent(wsi_pkg::req_type u);
      logic               has_stamp;
      logic               fresh;
      logic               moving;
      logic               sprint_seen;
      logic [47:0]        span;
      logic [19:0]        dt;
      logic [15:0]        raw;
      logic [16:0]        mag;
      logic [16:0]        move_thr;
      logic [16:0]        sprint_thr;
      wsi_pkg::cause_type why;
      wsi_pkg::rsp_type   r;

      has_stamp = (u.sample_time_ms != 48'd0) && (u.now_ms >= u.sample_time_ms);
      span      = has_stamp ? (u.now_ms - u.sample_time_ms) : 48'd0;
      fresh     = u.link_up && has_stamp &&
                  (span <= {28'd0, reg_shadow.stale_timeout_ms});
      dt        = (u.elapsed_us > {3'd0, wsi_pkg::DT_CAP_US}) ?
                  {3'd0, wsi_pkg::DT_CAP_US} : u.elapsed_us;
      raw       = u.stick_value;
      // -32768 has magnitude 32768, so work in 17 bits
      mag       = raw[15] ? (17'h1_0000 - {1'b0, raw}) : {1'b0, raw};
      why       = wsi_pkg::CAUSE_HOLD;

      if (!fresh) begin
         // stale drops to stopped; only a real drop reports the stale cause
         if (walk_mode != wsi_pkg::INTENT_STOPPED) why = wsi_pkg::CAUSE_STALE;
         walk_mode      = wsi_pkg::INTENT_STOPPED;
         still_us       = '0;
         sprint_held_us = '0;
         sprint_gone_us = '0;
      end else begin
         // a zero threshold behaves as one
         move_thr    = (reg_shadow.move_deadzone == '0) ? 17'd1 :
                       {1'b0, reg_shadow.move_deadzone};
         sprint_thr  = (reg_shadow.sprint_level == '0) ? 17'd1 :
                       {1'b0, reg_shadow.sprint_level};
         moving      = (mag >= move_thr);
         sprint_seen = u.device_sprint || (mag >= sprint_thr);

         still_us = moving ? 32'd0 : add_clamped(still_us, dt);
         if (sprint_seen) begin
            sprint_held_us = add_clamped(sprint_held_us, dt);
            sprint_gone_us = '0;
         end else begin
            sprint_gone_us = add_clamped(sprint_gone_us, dt);
            sprint_held_us = '0;
         end

         // coast expiry takes priority over either sprint transition
         case (walk_mode)
            wsi_pkg::INTENT_WALKING: begin
               if (!moving && still_us >= {5'd0, reg_shadow.coast_max_us}) begin
                  walk_mode = wsi_pkg::INTENT_STOPPED;
                  why       = wsi_pkg::CAUSE_COAST;
               end else if (sprint_held_us >= {5'd0, reg_shadow.sprint_enter_us}) begin
                  walk_mode = wsi_pkg::INTENT_SPRINTING;
                  why       = wsi_pkg::CAUSE_SPRINT_ENTER;
               end
            end
            wsi_pkg::INTENT_SPRINTING: begin
               if (!moving && still_us >= {5'd0, reg_shadow.coast_max_us}) begin
                  walk_mode = wsi_pkg::INTENT_STOPPED;
                  why       = wsi_pkg::CAUSE_COAST;
               end else if (sprint_gone_us >= {5'd0, reg_shadow.sprint_exit_us}) begin
                  walk_mode = wsi_pkg::INTENT_WALKING;
                  why       = wsi_pkg::CAUSE_SPRINT_EXIT;
               end
            end
            default: begin
               walk_mode = wsi_pkg::INTENT_STOPPED;
               if (moving) begin
                  walk_mode = wsi_pkg::INTENT_WALKING;
                  why       = wsi_pkg::CAUSE_START;
               end
            end
         endcase
      end

      r.intent      = walk_mode;
      r.cause       = why;
      r.is_stale    = !fresh;
      r.age_ms      = (has_stamp && span < {28'd0, wsi_pkg::AGE_CAP}) ?
                      span[19:0] : wsi_pkg::AGE_CAP;
      r.time_echo   = u.now_ms;
      r.seq_echo    = u.sample_seq;
      r.stick_echo  = u.stick_value;
      r.sprint_echo = u.device_sprint;
      r.drive_y     = (walk_mode == wsi_pkg::INTENT_STOPPED) ? 16'sd0 :
                      reg_shadow.forward_stick;
      r.button_mask = (walk_mode == wsi_pkg::INTENT_SPRINTING) ?
                      wsi_pkg::SHOULDER_BUTTON : 9'd0;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic log_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t mismatch on %s (result %0d): got %0h, want %0h",
                  $time, what, results_checked, got, want);
   endtask

   task automatic compare_result(wsi_pkg::rsp_type got, wsi_pkg::rsp_type want);
      if (got.intent !== want.intent)
         log_mismatch("intent", 64'(got.intent), 64'(want.intent));
      if (got.cause !== want.cause)
         log_mismatch("cause", 64'(got.cause), 64'(want.cause));
      if (got.is_stale !== want.is_stale)
         log_mismatch("is_stale", 64'(got.is_stale), 64'(want.is_stale));
      if (got.age_ms !== want.age_ms)
         log_mismatch("age_ms", 64'(got.age_ms), 64'(want.age_ms));
      if (got.time_echo !== want.time_echo)
         log_mismatch("time_echo", 64'(got.time_echo), 64'(want.time_echo));
      if (got.seq_echo !== want.seq_echo)
         log_mismatch("seq_echo", 64'(got.seq_echo), 64'(want.seq_echo));
      if (got.stick_echo !== want.stick_echo)
         log_mismatch("stick_echo", 64'(got.stick_echo), 64'(want.stick_echo));
      if (got.sprint_echo !== want.sprint_echo)
         log_mismatch("sprint_echo", 64'(got.sprint_echo), 64'(want.sprint_echo));
      if (got.drive_y !== want.drive_y)
         log_mismatch("drive_y", 64'(got.drive_y), 64'(want.drive_y));
      if (got.button_mask !== want.button_mask)
         log_mismatch("button_mask", 64'(got.button_mask), 64'(want.button_mask));
   endtask

   // Sample all three channels at the rising edge. Predict on the req transfer
   // before the result check, so both happen in one fixed order per edge.
   always @(posedge clock) begin
      cycle_count++;
      req_took <= req_valid && !req_stall;
      csr_took <= csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            // mirror the register write; the unused index is dropped
            case (csr_index)
               wsi_pkg::CSR_MOVE_DEADZONE:
                  reg_shadow.move_deadzone    = csr_wdata[15:0];
               wsi_pkg::CSR_SPRINT_LEVEL:
                  reg_shadow.sprint_level     = csr_wdata[15:0];
               wsi_pkg::CSR_STALE_TIMEOUT_MS:
                  reg_shadow.stale_timeout_ms = csr_wdata[19:0];
               wsi_pkg::CSR_COAST_MAX_US:
                  reg_shadow.coast_max_us     = csr_wdata[26:0];
               wsi_pkg::CSR_SPRINT_ENTER_US:
                  reg_shadow.sprint_enter_us  = csr_wdata[26:0];
               wsi_pkg::CSR_SPRINT_EXIT_US:
                  reg_shadow.sprint_exit_us   = csr_wdata[26:0];
               wsi_pkg::CSR_FORWARD_STICK:
                  reg_shadow.forward_stick    = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            intent_next = predict_intent(req_data);
            intent_due.push_back(intent_next);
            cause_tally[intent_next.cause]++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (intent_due.size() == 0) begin
               log_mismatch("result with nothing expected", 64'(rsp_data.seq_echo), 64'd0);
            end else begin
               intent_next = intent_due.pop_front();
               compare_result(rsp_data, intent_next);
               results_checked++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: change inputs at the falling edge only
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      // hold the payload until its transfer, then advance or idle
      if (!req_valid || req_took) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (update_queue.size() != 0) begin
            req_data  <= update_queue.pop_front();
            req_valid <= 1'b1;
            if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds)
               req_gap = $urandom_range(1, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end

      // result backpressure in bursts whose length rsp_gap draws at random
      if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds / 2) begin
         rsp_gap = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic write_reg(logic [2:0] idx, logic [wsi_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(wsi_pkg::cfg_type c);
      write_reg(wsi_pkg::CSR_MOVE_DEADZONE,    27'(c.move_deadzone));
      write_reg(wsi_pkg::CSR_SPRINT_LEVEL,     27'(c.sprint_level));
      write_reg(wsi_pkg::CSR_STALE_TIMEOUT_MS, 27'(c.stale_timeout_ms));
      write_reg(wsi_pkg::CSR_COAST_MAX_US,     c.coast_max_us);
      write_reg(wsi_pkg::CSR_SPRINT_ENTER_US,  c.sprint_enter_us);
      write_reg(wsi_pkg::CSR_SPRINT_EXIT_US,   c.sprint_exit_us);
      write_reg(wsi_pkg::CSR_FORWARD_STICK,    {11'd0, c.forward_stick});
      write_reg(CSR_UNUSED,                    27'($urandom));
      setting_count++;
   endtask

   // Wait until no update is queued, in flight or owed, then let the pipe drain.
   // Check at the rising edge, where the driver's inputs are settled.
   task automatic settle();
      do @(posedge clock);
      while (update_queue.size() != 0 || req_valid || intent_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Jump the wall clock to a random point, kept clear of both ends of 48 bits.
   task automatic reseed_clock();
      now_clk = 48'({$urandom, $urandom});
      if (now_clk < 48'h40_0000) now_clk = now_clk + 48'h40_0000;
      if (now_clk > 48'hFFFF_0000_0000) now_clk = now_clk - 48'h1_0000_0000;
   endtask

   task automatic push_update(bit link, logic signed [15:0] stick, bit sprint,
                              logic [19:0] elapsed, logic [47:0] stamp);
      wsi_pkg::req_type u;
      u.link_up        = link;
      u.stick_value    = stick;
      u.device_sprint  = sprint;
      u.sample_time_ms = stamp;
      u.now_ms         = now_clk;
      u.elapsed_us     = elapsed;
      u.sample_seq     = $urandom;
      update_queue.push_back(u);
      now_clk = now_clk + 48'($urandom_range(0, 40));
   endtask

   function automatic logic signed [15:0] stick_from(int mag, bit neg);
      if (mag < 0) mag = 0;
      if (mag >= 32768) return 16'sh8000;
      return neg ? 16'(-mag) : 16'(mag);
   endfunction

   function automatic logic [19:0] pick_elapsed();
      case ($urandom_range(0, 9))
         0:       return 20'd0;
         1:       return {3'd0, wsi_pkg::DT_CAP_US};
         2:       return {3'd0, wsi_pkg::DT_CAP_US} + 20'd1;
         3, 4, 5: return 20'($urandom_range(0, 50000));
         default: return 20'($urandom_range(50000, 1000000));
      endcase
   endfunction

   // sample age that still counts as fresh, edges favored
   function automatic logic [47:0] pick_age();
      case ($urandom_range(0, 3))
         0:       return 48'd0;
         1:       return 48'(reg_shadow.stale_timeout_ms);
         default: return 48'($urandom_range(0, reg_shadow.stale_timeout_ms));
      endcase
   endfunction

   function automatic logic [15:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return ($urandom_range(0, 1) != 0) ? 16'd0 : 16'd32768;
         1:       return 16'($urandom_range(0, 300));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic logic [26:0] pick_span();
      case ($urandom_range(0, 7))
         0:       return 27'd0;
         1:       return 27'd100000000;
         default: return 27'($urandom_range(0, 600000));
      endcase
   endfunction

   // Broken or odd updates: link down, no stamp, future stamp, too old, noise.
   task automatic push_noise();
      logic [47:0] span;
      case ($urandom_range(0, 5))
         0: push_update(1'b0, 16'($urandom), 1'($urandom), pick_elapsed(), now_clk - pick_age());
         1: push_update(1'($urandom), 16'($urandom), 1'($urandom), pick_elapsed(), 48'd0);
         2: push_update(1'b1, 16'($urandom), 1'($urandom), pick_elapsed(),
                        now_clk + 48'($urandom_range(1, 1000)));
         3: begin
            span = 48'(reg_shadow.stale_timeout_ms) + 48'd1 + 48'($urandom_range(0, 2000000));
            push_update(1'b1, 16'($urandom), 1'($urandom), pick_elapsed(), now_clk - span);
         end
         4: begin
            // fully random stamps; now rides along through the running clock
            now_clk = 48'({$urandom, $urandom});
            push_update(1'($urandom), 16'($urandom), 1'($urandom),
                        20'($urandom_range(0, 1000000)), 48'({$urandom, $urandom}));
            reseed_clock();
         end
         default: push_update(1'b1, 16'($urandom), 1'($urandom), pick_elapsed(),
                              now_clk - pick_age());
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      wsi_pkg::cfg_type c;
      int      ph;
      int      n;
      int      k;
      int      len;
      int      target;
      bit      neg;
      bit      dev;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);

      // Registers at reset values first, then written back once explicitly
      apply_config(reg_shadow);
      reseed_clock();
      gap_odds = 20;

      // Freshness edges, stick extremes, elapsed clamp and the basic transitions
      @(posedge clock);
      push_update(1'b1, 16'sd32767, 1'b1, 20'd100000, 48'd0);              // no stamp
      push_update(1'b1, 16'sd5000, 1'b0, 20'd100000, now_clk + 48'd5);     // future stamp
      push_update(1'b1, 16'sd5000, 1'b0, 20'd50000, now_clk - 48'd500);    // age at limit
      push_update(1'b1, 16'sh8000, 1'b0, 20'd1000000, now_clk);            // clamp, full neg
      push_update(1'b1, 16'sd100, 1'b1, 20'd100000, now_clk - 48'd1);      // sprint enter
      push_update(1'b0, 16'sd5000, 1'b0, 20'd100000, now_clk);             // drop on stale
      push_update(1'b1, 16'sd4000, 1'b0, 20'd100000, now_clk - 48'd501);   // just too old
      push_update(1'b1, 16'sd4000, 1'b0, 20'd100000, now_clk - 48'd3);     // deadzone edge
      repeat (3) push_update(1'b1, -16'sd3999, 1'b0, 20'd100000, now_clk); // coast out
      push_update(1'b1, 16'sd32767, 1'b1, 20'd0, now_clk - 48'd2000000);   // age over cap
      settle();

      // Equal timers: coast has to beat both sprint transitions
      c                 = reg_shadow;
      c.coast_max_us    = 27'd100000;
      c.sprint_enter_us = 27'd100000;
      c.sprint_exit_us  = 27'd100000;
      c.forward_stick   = 16'sh8000;
      apply_config(c);
      @(posedge clock);
      push_update(1'b1, 16'sd5000, 1'b0, 20'd0, now_clk);
      push_update(1'b1, 16'sd0, 1'b1, 20'd100000, now_clk);
      push_update(1'b1, 16'sd5000, 1'b0, 20'd0, now_clk);
      push_update(1'b1, 16'sd32767, 1'b0, 20'd100000, now_clk);
      push_update(1'b1, 16'sd0, 1'b0, 20'd100000, now_clk);
      push_update(1'b1, -16'sd5000, 1'b0, 20'd0, now_clk);
      push_update(1'b1, -16'sd30000, 1'b0, 20'd100000, now_clk);
      push_update(1'b1, 16'sd5000, 1'b0, 20'd100000, now_clk);
      settle();

      // Hold in stopped with sprint on: the sprint timer keeps building, so the
      // first moving update starts walking and the next one enters sprinting.
      c.sprint_enter_us = 27'd200000;
      apply_config(c);
      gap_odds = 0;
      @(posedge clock);
      repeat (SOAK_LEN) push_update(1'b1, 16'sd0, 1'b1, 20'd100000, now_clk);
      push_update(1'b1, 16'sd5000, 1'b1, 20'd0, now_clk);
      push_update(1'b1, 16'sd5000, 1'b1, 20'd0, now_clk);
      settle();

      // Random phases: low extremes, high extremes, then random settings.
      // Most updates come as fresh runs of similar stick so timers build up.
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: c = '{move_deadzone: 16'd0, sprint_level: 16'd0, stale_timeout_ms: 20'd0,
                     coast_max_us: 27'd0, sprint_enter_us: 27'd0, sprint_exit_us: 27'd0,
                     forward_stick: 16'sh8000};
            1: c = '{move_deadzone: 16'd32768, sprint_level: 16'd32768,
                     stale_timeout_ms: 20'd999999, coast_max_us: 27'd100000000,
                     sprint_enter_us: 27'd100000000, sprint_exit_us: 27'd100000000,
                     forward_stick: 16'sd32767};
            default: begin
               c.move_deadzone    = pick_level();
               c.sprint_level     = pick_level();
               c.stale_timeout_ms = ($urandom_range(0, 4) == 0) ?
                                    20'($urandom_range(0, 999999)) :
                                    20'($urandom_range(0, 3000));
               c.coast_max_us     = pick_span();
               c.sprint_enter_us  = pick_span();
               c.sprint_exit_us   = pick_span();
               c.forward_stick    = 16'($urandom);
            end
         endcase
         apply_config(c);
         case (ph)
            2, 5:    gap_odds = 0;   // a stretch at full rate; the last phase stays calm
            3:       gap_odds = 35;
            default: gap_odds = 15;
         endcase
         reseed_clock();
         @(posedge clock);
         n = 0;
         while (n < PHASE_LEN) begin
            if ($urandom_range(0, 99) < 15) begin
               push_noise();
               n++;
            end else begin
               len = $urandom_range(1, 12);
               neg = $urandom_range(0, 1);
               dev = ($urandom_range(0, 3) == 0);
               case ($urandom_range(0, 4))
                  0:       target = int'(reg_shadow.move_deadzone);
                  1:       target = int'(reg_shadow.sprint_level);
                  2:       target = $urandom_range(0, 300);
                  3:       target = $urandom_range(0, 32768);
                  default: target = $urandom_range(32766, 32768);
               endcase
               for (k = 0; k < len && n < PHASE_LEN; k++) begin
                  push_update(1'b1, stick_from(target + $urandom_range(0, 4) - 2, neg),
                              dev ^ ($urandom_range(0, 9) == 0), pick_elapsed(),
                              now_clk - pick_age());
                  n++;
               end
            end
         end
         settle();
      end

      repeat (10) @(negedge clock);
      if (intent_due.size() != 0)
         log_mismatch("results never delivered", 64'd0, 64'(intent_due.size()));

      $display("checked %0d results across %0d register settings, incl. a %0d-update sprint hold",
               results_checked, setting_count, SOAK_LEN);
      $display("causes: hold %0d stale %0d start %0d coast %0d enter %0d exit %0d",
               cause_tally[wsi_pkg::CAUSE_HOLD], cause_tally[wsi_pkg::CAUSE_STALE],
               cause_tally[wsi_pkg::CAUSE_START], cause_tally[wsi_pkg::CAUSE_COAST],
               cause_tally[wsi_pkg::CAUSE_SPRINT_ENTER],
               cause_tally[wsi_pkg::CAUSE_SPRINT_EXIT]);
      if (mismatch_count == 0) begin
         $display("[walk_sprint_intent_fsm] OK");
      end else begin
         $display("[walk_sprint_intent_fsm] ERROR");
      end
      $finish;
   end

   // Watchdog: end a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, intent_due.size());
      $display("[walk_sprint_intent_fsm] ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
src/wsi_pkg.sv
src/wsi_front.sv
src/wsi_queue.sv
src/wsi_back.sv
src/walk_sprint_intent_fsm.sv
tb/sv/tb_top.sv
